// ===== rtl/plsub_pkg.sv =====
`timescale 1ns / 1ps

package plsub_pkg;

  localparam int COORD_W    = 32;
  localparam int NUM_COORDS = 4;
  localparam int CUT_W      = 4;
  localparam int DIV_W      = CUT_W + 1;
  localparam int COORD_IDX_W = $clog2(NUM_COORDS);
  localparam int IN_DATA_W  = (NUM_COORDS + 1) * COORD_W;
  localparam int OUT_USER_W = 3;
  // two quotient bits per cycle
  localparam int DIV_CYCLES = COORD_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);
  localparam int ADDR_W     = 3;

  // register index, taken from paddr[2]
  localparam logic REG_CUT_COUNT = 1'b0;
  localparam logic REG_CYCLIC    = 1'b1;

  typedef struct packed {
    logic [NUM_COORDS-1:0][COORD_W-1:0] c;
    logic [COORD_W-1:0]                 radius;
    logic                               sel;
  } point_t;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_START    = 6'b000010,
    ST_DIV_LOAD = 6'b000100,
    ST_DIV_RUN  = 6'b001000,
    ST_STEP     = 6'b010000,
    ST_WAIT     = 6'b100000
  } state_t;

endpackage

// ===== rtl/polyline_linear_subdivider_unit.sv =====
`timescale 1ns / 1ps
// channel  dir  beat fields
// s_*      in   tdata: coord_x, coord_y, coord_z, coord_w, point_radius;
//               tuser: point_selected; tlast: curve_end
// m_*      out  tdata: out_x, out_y, out_z, out_w, out_radius;
//               tuser: out_selected, out_inserted, curve_done; tlast: run_last
// apb      in   0x0 cut_count (4b), 0x4 cyclic_mode (1b)
//
// One point at a time: s_tready is high only while no point is in work.
// Each original point goes out from ST_START through ST_WAIT, held there by any m_tready stall.
// A selected segment first runs the shared 2-bit/cycle divider over the four
// coordinate deltas (ST_DIV_LOAD, then ST_DIV_RUN), then builds each inserted point in ST_STEP.
// rst (sync) clears curve state, sets cut_count to 1 and cyclic_mode to 0.
module polyline_linear_subdivider_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [plsub_pkg::IN_DATA_W-1:0] s_tdata,  // x, y, z, w, radius
  input  logic                            s_tuser,  // point_selected
  input  logic                            s_tlast,  // curve_end
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [plsub_pkg::IN_DATA_W-1:0] m_tdata,  // x, y, z, w, radius
  output logic [plsub_pkg::OUT_USER_W-1:0] m_tuser, // selected, inserted, curve_done
  output logic                            m_tlast,  // run_last
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [plsub_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import plsub_pkg::*;

  state_t state;

  logic [CUT_W-1:0] cut_count;
  logic             cyclic_mode;

  point_t prev_point, first_point, seg_a, seg_b, out_pt, cur;
  logic   have_prev, cuts_en, more_seg, item_end;
  logic   out_inserted, run_last;

  logic [COORD_IDX_W-1:0] j;
  logic [DIV_CNT_W-1:0]   div_cnt;
  logic [CUT_W-1:0]       pt_idx;

  logic [COORD_W-1:0] dq;
  logic [CUT_W-1:0]   rem;

  logic [COORD_W-1:0] quo [NUM_COORDS];
  logic [CUT_W-1:0]   rmd [NUM_COORDS];
  logic [COORD_W-1:0] acq [NUM_COORDS];
  logic [CUT_W-1:0]   acr [NUM_COORDS];
  logic               neg [NUM_COORDS];

  logic [DIV_W-1:0]   dvs;
  logic               do_cuts;
  logic [COORD_W:0]   diff;
  logic [COORD_W-1:0] mag;
  logic [DIV_W-1:0]   t1, t2;
  logic               ge1, ge2;
  logic [CUT_W-1:0]   r1, rem_next;
  logic [COORD_W-1:0] dq1, dq_next;
  logic [DIV_W-1:0]   sum_r;
  logic               wrap;
  logic [CUT_W-1:0]   acr_next;
  logic [COORD_W-1:0] acq_next, coord_next;
  logic               cfg_wr;

  assign cur.c      = s_tdata[NUM_COORDS*COORD_W-1:0];
  assign cur.radius = s_tdata[IN_DATA_W-1:NUM_COORDS*COORD_W];
  assign cur.sel    = s_tuser;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_WAIT);
  assign m_tdata  = {out_pt.radius, out_pt.c};
  assign m_tuser  = {run_last & item_end, out_inserted, out_pt.sel};
  assign m_tlast  = run_last;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_CYCLIC) ? {31'd0, cyclic_mode}
                                           : {{(32-CUT_W){1'b0}}, cut_count};

  assign dvs     = {1'b0, cut_count} + DIV_W'(1);
  assign do_cuts = cuts_en & seg_a.sel & seg_b.sel & (cut_count != '0);

  // delta and magnitude of the current coordinate
  always_comb begin
    diff = {seg_b.c[j][COORD_W-1], seg_b.c[j]} - {seg_a.c[j][COORD_W-1], seg_a.c[j]};
    mag  = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
  end

  // restoring divider, two quotient bits per cycle; remainder stays below dvs
  always_comb begin
    t1       = {rem, dq[COORD_W-1]};
    ge1      = (t1 >= dvs);
    r1       = ge1 ? CUT_W'(t1 - dvs) : t1[CUT_W-1:0];
    dq1      = {dq[COORD_W-2:0], ge1};
    t2       = {r1, dq1[COORD_W-1]};
    ge2      = (t2 >= dvs);
    rem_next = ge2 ? CUT_W'(t2 - dvs) : t2[CUT_W-1:0];
    dq_next  = {dq1[COORD_W-2:0], ge2};
  end

  // offset i of a segment: floor((i*mag + dvs/2) / dvs), kept as quotient+remainder
  always_comb begin
    sum_r      = {1'b0, acr[j]} + {1'b0, rmd[j]};
    wrap       = (sum_r >= dvs);
    acr_next   = wrap ? CUT_W'(sum_r - dvs) : sum_r[CUT_W-1:0];
    acq_next   = acq[j] + quo[j] + COORD_W'(wrap);
    coord_next = neg[j] ? seg_a.c[j] - acq_next : seg_a.c[j] + acq_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cut_count   <= CUT_W'(1);
      cyclic_mode <= 1'b0;
      have_prev   <= 1'b0;
      prev_point  <= '0;
      first_point <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_CUT_COUNT: cut_count   <= pwdata[CUT_W-1:0];
          REG_CYCLIC:    cyclic_mode <= pwdata[0];
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            item_end   <= s_tlast;
            prev_point <= cur;
            seg_b      <= cur;
            if (!have_prev) begin
              first_point <= cur;
              seg_a       <= cur;
              cuts_en     <= cyclic_mode;
              more_seg    <= 1'b0;
              have_prev   <= ~s_tlast;
              if (s_tlast) state <= ST_START;
            end else begin
              seg_a    <= prev_point;
              cuts_en  <= 1'b1;
              more_seg <= s_tlast;
              if (s_tlast) have_prev <= 1'b0;
              state <= ST_START;
            end
          end
        end
        ST_START: begin
          out_pt       <= seg_a;
          out_inserted <= 1'b0;
          run_last     <= ~do_cuts & ~more_seg;
          state        <= ST_WAIT;
        end
        ST_DIV_LOAD: begin
          neg[j]  <= diff[COORD_W];
          dq      <= mag;
          rem     <= '0;
          div_cnt <= '0;
          state   <= ST_DIV_RUN;
        end
        ST_DIV_RUN: begin
          dq      <= dq_next;
          rem     <= rem_next;
          div_cnt <= div_cnt + DIV_CNT_W'(1);
          if (div_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
            quo[j] <= dq_next;
            rmd[j] <= rem_next;
            acq[j] <= '0;
            acr[j] <= dvs[DIV_W-1:1];
            j      <= j + COORD_IDX_W'(1);
            if (j == COORD_IDX_W'(NUM_COORDS - 1)) begin
              pt_idx <= CUT_W'(1);
              state  <= ST_STEP;
            end else begin
              state <= ST_DIV_LOAD;
            end
          end
        end
        ST_STEP: begin
          acq[j]      <= acq_next;
          acr[j]      <= acr_next;
          out_pt.c[j] <= coord_next;
          j           <= j + COORD_IDX_W'(1);
          if (j == COORD_IDX_W'(NUM_COORDS - 1)) begin
            out_pt.radius <= seg_b.radius;
            out_pt.sel    <= seg_b.sel;
            out_inserted  <= 1'b1;
            run_last      <= (pt_idx == cut_count) & ~more_seg;
            state         <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (m_tready) begin
            j <= '0;
            if (!out_inserted && do_cuts) begin
              state <= ST_DIV_LOAD;
            end else if (out_inserted && (pt_idx != cut_count)) begin
              pt_idx <= pt_idx + CUT_W'(1);
              state  <= ST_STEP;
            end else if (more_seg) begin
              // closing segment, or the lone tail point of an open curve
              seg_a    <= seg_b;
              seg_b    <= first_point;
              cuts_en  <= cyclic_mode;
              more_seg <= 1'b0;
              state    <= ST_START;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/plsub_checker.sv =====
`timescale 1ns / 1ps
module plsub_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [plsub_pkg::IN_DATA_W-1:0]  m_tdata,
  input logic [plsub_pkg::OUT_USER_W-1:0] m_tuser,
  input logic                             m_tlast,
  input logic                             pready
);
  import plsub_pkg::*;

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output beat changed while stalled");

  // one point in work at a time: no input taken while a result is pending
  a_busy: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while output pending");

  // curve end only on the last beat of a run
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tlast)
    else $error("curve_done without run_last");

  // after the last beat of a run the block takes the next point
  a_run_ready: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
    else $error("not ready after run end");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind polyline_linear_subdivider_unit plsub_checker u_plsub_checker (.*);

// ===== test/polyline_linear_subdivider_unit_test.sv =====
`timescale 1ns / 1ps

module polyline_linear_subdivider_unit_test;
  import plsub_pkg::*;

  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 36;

  typedef struct packed {
    point_t pt;
    logic   inserted;
    logic   run_last;
    logic   done;
  } out_point_t;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata;   // x, y, z, w, radius
  logic s_tuser;                   // point_selected
  logic s_tlast;                   // curve_end
  logic m_tvalid;
  logic m_tready;
  logic [IN_DATA_W-1:0] m_tdata;   // x, y, z, w, radius
  logic [OUT_USER_W-1:0] m_tuser;  // selected, inserted, curve_done
  logic m_tlast;                   // run_last
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // predictor state
  point_t     prev_pt;
  point_t     first_pt;
  logic       curve_open = 1'b0;
  logic [3:0] cuts_reg = 4'd1;
  logic       cyclic_reg = 1'b0;
  out_point_t expected_points[$];

  int   error_count = 0;
  logic gaps_enabled = 1'b1;
  logic hold_request = 1'b0;

  polyline_linear_subdivider_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] lerp_coord(logic [31:0] a, logic [31:0] b,
                                             int unsigned k, int unsigned d);
    logic signed [63:0] sa, diff;
    logic [63:0] mag, q, r;
    sa = {{32{a[31]}}, a};
    diff = {{32{b[31]}}, b} - sa;
    mag = diff[63] ? -diff : diff;
    // round half away from zero on the magnitude of the offset
    q = (mag * k + d / 2) / d;
    r = diff[63] ? sa - q : sa + q;
    return r[31:0];
  endfunction

  function automatic void push_point(point_t p, logic ins);
    out_point_t r;
    r.pt = p;
    r.inserted = ins;
    r.run_last = 1'b0;
    r.done = 1'b0;
    expected_points.push_back(r);
  endfunction

  function automatic void push_segment(point_t a, point_t b);
    point_t q;
    int unsigned n;
    n = cuts_reg;
    push_point(a, 1'b0);
    if (a.sel && b.sel) begin
      for (int unsigned i = 1; i <= n; i++) begin
        q = b;
        for (int j = 0; j < NUM_COORDS; j++) begin
          q.c[j] = lerp_coord(a.c[j], b.c[j], i, n + 1);
        end
        push_point(q, 1'b1);
      end
    end
  endfunction

  function automatic void predict_subdivision(point_t p, logic last);
    int base;
    out_point_t tail;
    base = expected_points.size();
    if (!curve_open) begin
      first_pt = p;
      prev_pt = p;
      if (last) begin
        if (cyclic_reg) begin
          push_segment(p, p);
        end else begin
          push_point(p, 1'b0);
        end
      end else begin
        curve_open = 1'b1;
      end
    end else begin
      push_segment(prev_pt, p);
      prev_pt = p;
      if (last) begin
        if (cyclic_reg) begin
          push_segment(p, first_pt);
        end else begin
          push_point(p, 1'b0);
        end
        curve_open = 1'b0;
      end
    end
    if (expected_points.size() > base) begin
      tail = expected_points.pop_back();
      tail.run_last = 1'b1;
      tail.done = last;
      expected_points.push_back(tail);
    end
  endfunction

  function automatic logic [31:0] field_of(out_point_t r, int i);
    case (i)
      0, 1, 2, 3: return r.pt.c[i];
      4: return r.pt.radius;
      5: return {31'b0, r.pt.sel};
      6: return {31'b0, r.inserted};
      7: return {31'b0, r.run_last};
      default: return {31'b0, r.done};
    endcase
  endfunction

  function automatic string field_label(int i);
    case (i)
      0: return "out_x";
      1: return "out_y";
      2: return "out_z";
      3: return "out_w";
      4: return "out_radius";
      5: return "out_selected";
      6: return "out_inserted";
      7: return "run_last";
      default: return "curve_done";
    endcase
  endfunction

  function automatic void note_error(string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endfunction

  function automatic void check_point();
    out_point_t got, want;
    for (int j = 0; j < NUM_COORDS; j++) begin
      got.pt.c[j] = m_tdata[COORD_W*j +: COORD_W];
    end
    got.pt.radius = m_tdata[IN_DATA_W-1 -: COORD_W];
    got.pt.sel = m_tuser[0];
    got.inserted = m_tuser[1];
    got.done = m_tuser[2];
    got.run_last = m_tlast;
    if (expected_points.size() == 0) begin
      note_error($sformatf("unexpected output beat x=%h y=%h", got.pt.c[0], got.pt.c[1]));
    end else begin
      want = expected_points.pop_front();
      for (int i = 0; i < 9; i++) begin
        if (field_of(got, i) !== field_of(want, i)) begin
          note_error($sformatf("%s expected %h got %h", field_label(i),
                               field_of(want, i), field_of(got, i)));
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      check_point();
    end
  end

  // output side: random stalls, plus one long hold on request
  initial begin : result_sink
    int stall;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = gaps_enabled ? $urandom_range(0, 4) : 0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // leaves tvalid high so a following send with no gap keeps the bus busy
  task automatic send_point(point_t p, logic last);
    int gap;
    gap = gaps_enabled ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {p.radius, p.c[3], p.c[2], p.c[1], p.c[0]};
    s_tuser <= p.sel;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    predict_subdivision(p, last);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write, then read back in the same transfer burst
  task automatic program_reg(logic idx, logic [31:0] value);
    logic [31:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_CUT_COUNT) begin
      cuts_reg = value[3:0];
      want = {28'b0, value[3:0]};
    end else begin
      cyclic_reg = value[0];
      want = {31'b0, value[0]};
    end
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      note_error($sformatf("register %0d read expected %h got %h", idx, want, prdata));
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(logic [3:0] cuts, logic cyclic);
    logic [31:0] junk;
    wait_idle();
    junk = $urandom();
    program_reg(REG_CUT_COUNT, {junk[31:4], cuts});
    junk = $urandom();
    program_reg(REG_CYCLIC, {junk[31:1], cyclic});
  endtask

  function automatic point_t mk_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                      logic [31:0] w, logic [31:0] r, logic sel);
    point_t p;
    p.c[0] = x;
    p.c[1] = y;
    p.c[2] = z;
    p.c[3] = w;
    p.radius = r;
    p.sel = sel;
    return p;
  endfunction

  function automatic point_t rand_point(point_t near);
    point_t p;
    for (int j = 0; j < NUM_COORDS; j++) begin
      case ($urandom_range(0, 5))
        0, 1: p.c[j] = $urandom();
        // small steps give many rounding ties
        2: p.c[j] = near.c[j] + $urandom_range(0, 64) - 32;
        3: begin
          case ($urandom_range(0, 3))
            0: p.c[j] = 32'h8000_0000;
            1: p.c[j] = 32'h7fff_ffff;
            2: p.c[j] = 32'h0000_0000;
            default: p.c[j] = 32'hffff_ffff;
          endcase
        end
        default: p.c[j] = $urandom_range(0, 32'h0003_ffff) - 32'h0002_0000;
      endcase
    end
    p.radius = $urandom();
    p.sel = $urandom_range(0, 9) < 8;
    return p;
  endfunction

  // reset values: one cut, open curve; also the half-way ties
  task automatic test_rounding_defaults();
    send_point(mk_point(0, 0, 0, 0, 32'h0, 1'b1), 1'b0);
    send_point(mk_point(1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                        32'hffff_ffff, 1'b1), 1'b0);
    send_point(mk_point(32'h8000_0000, 32'h7fff_ffff, 1, 32'hffff_ffff,
                        32'h1234_5678, 1'b0), 1'b1);
  endtask

  task automatic test_single_point_curves();
    set_mode(4'd15, 1'b1);
    send_point(mk_point(32'h0001_0000, 32'hfffe_0000, 5, 7, 32'h0002_8000, 1'b1), 1'b1);
    send_point(mk_point(32'h0003_0000, 9, 32'h8000_0000, 0, 32'h0000_4000, 1'b0), 1'b1);
    set_mode(4'd15, 1'b0);
    send_point(mk_point(11, 22, 33, 44, 55, 1'b1), 1'b1);
    set_mode(4'd0, 1'b1);
    send_point(mk_point(32'h7fff_ffff, 1, 2, 3, 4, 1'b1), 1'b1);
  endtask

  task automatic test_full_span();
    set_mode(4'd15, 1'b0);
    send_point(mk_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h0, 1'b1), 1'b0);
    send_point(mk_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'hffff_ffff, 1'b1), 1'b0);
    // one end unselected: no inserted points
    send_point(mk_point(32'h8000_0000, 0, 32'h7fff_ffff, 32'hffff_ffff,
                        32'h0001_0000, 1'b0), 1'b1);
  endtask

  task automatic test_cyclic_closing();
    set_mode(4'd3, 1'b1);
    send_point(mk_point(0, 0, 0, 32'h0001_0000, 32'h100, 1'b1), 1'b0);
    send_point(mk_point(32'h0004_0000, 7, 32'hffff_fff0, 32'h0001_0000, 32'h200, 1'b1), 1'b0);
    send_point(mk_point(32'hfffc_0000, 3, 32'h0000_0011, 32'h0002_0000, 32'h300, 1'b1), 1'b1);
    set_mode(4'd0, 1'b1);
    send_point(mk_point(5, 6, 7, 8, 9, 1'b0), 1'b0);
    send_point(mk_point(15, 16, 17, 18, 19, 1'b1), 1'b0);
    send_point(mk_point(25, 26, 27, 28, 29, 1'b1), 1'b1);
  endtask

  // both registers change with a curve open; cyclic_mode counts at its end
  task automatic test_mid_curve_writes();
    set_mode(4'd2, 1'b0);
    send_point(mk_point(0, 100, 200, 300, 1, 1'b1), 1'b0);
    send_point(mk_point(60, 40, 20, 0, 2, 1'b1), 1'b0);
    wait_idle();
    program_reg(REG_CUT_COUNT, 32'd5);
    program_reg(REG_CYCLIC, 32'd1);
    send_point(mk_point(32'hffff_ff00, 32'h0000_0100, 1, 32'h8000_0000, 3, 1'b1), 1'b1);
  endtask

  // receiver holds off while points keep coming, so the input stalls
  task automatic test_output_stall();
    point_t p;
    set_mode(4'd15, 1'b0);
    gaps_enabled = 1'b0;
    hold_request = 1'b1;
    p = mk_point(0, 0, 0, 0, 0, 1'b1);
    for (int i = 0; i < 6; i++) begin
      p = rand_point(p);
      p.sel = 1'b1;
      send_point(p, i == 5);
    end
    gaps_enabled = 1'b1;
  endtask

  task automatic test_random_curves();
    point_t p;
    int sent;
    int len;
    logic [3:0] cuts;
    logic cyclic;
    p = mk_point(0, 0, 0, 0, 0, 1'b1);
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin cuts = 4'd15; cyclic = 1'b1; end
        1: begin cuts = 4'd0; cyclic = 1'b0; end
        2: begin cuts = 4'd15; cyclic = 1'b0; end
        3: begin cuts = 4'd0; cyclic = 1'b1; end
        default: begin
          cuts = $urandom_range(0, 15);
          cyclic = $urandom_range(0, 1);
        end
      endcase
      set_mode(cuts, cyclic);
      gaps_enabled = $urandom_range(0, 3) != 0;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 7);
        for (int i = 0; i < len; i++) begin
          p = rand_point(p);
          send_point(p, i == len - 1);
        end
        sent += len;
      end
    end
    gaps_enabled = 1'b1;
  endtask

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= 1'b0;
    s_tlast <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_rounding_defaults();
    test_single_point_curves();
    test_full_span();
    test_cyclic_closing();
    test_mid_curve_writes();
    test_output_stall();
    test_random_curves();
    wait_idle();
    if (error_count == 0) begin
      $display("polyline_linear_subdivider_unit regression: pass");
    end else begin
      $display("polyline_linear_subdivider_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("polyline_linear_subdivider_unit regression: fail");
    $finish;
  end

endmodule
